/* rtl/cbs_pkg.sv */
`default_nettype none
package cbs_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_BITS    = 4;
  localparam int NUM_STAGES      = 6;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_X = 4'd0,
    CFG_START_Y = 4'd1,
    CFG_CTRL1_X = 4'd2,
    CFG_CTRL1_Y = 4'd3,
    CFG_CTRL2_X = 4'd4,
    CFG_CTRL2_Y = 4'd5,
    CFG_END_X   = 4'd6,
    CFG_END_Y   = 4'd7
  } cfg_reg_t;

  // Load enables for the two register stages of one interpolation unit.
  typedef struct packed {
    logic mul;
    logic add;
  } lerp_en_t;

endpackage
`default_nettype wire

/* rtl/cbs_intf.sv */
`default_nettype none
interface cbs_in_if #(
  parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [T_FRAC_BITS:0] param_t;

  modport source (output valid, output param_t, input ready);
  modport sink   (input valid, input param_t, output ready);
endinterface

interface cbs_out_if #(
  parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_mid_x;
  logic signed [COORD_BITS-1:0] first_mid_y;
  logic signed [COORD_BITS-1:0] first_inner_x;
  logic signed [COORD_BITS-1:0] first_inner_y;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] second_inner_x;
  logic signed [COORD_BITS-1:0] second_inner_y;
  logic signed [COORD_BITS-1:0] second_mid_x;
  logic signed [COORD_BITS-1:0] second_mid_y;

  modport source (output valid, output first_mid_x, output first_mid_y,
                  output first_inner_x, output first_inner_y, output point_x,
                  output point_y, output second_inner_x, output second_inner_y,
                  output second_mid_x, output second_mid_y, input ready);
  modport sink   (input valid, input first_mid_x, input first_mid_y,
                  input first_inner_x, input first_inner_y, input point_x,
                  input point_y, input second_inner_x, input second_inner_y,
                  input second_mid_x, input second_mid_y, output ready);
endinterface

interface cbs_cfg_if #(
  parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [cbs_pkg::CFG_IDX_BITS-1:0]  index;
  logic signed [COORD_BITS-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/cbs_lerp.sv */
`default_nettype none
module cbs_lerp #(
  parameter int COORD_BITS  = cbs_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire cbs_pkg::lerp_en_t            en,
  input  wire logic signed [COORD_BITS-1:0] a,
  input  wire logic signed [COORD_BITS-1:0] b,
  input  wire logic [T_FRAC_BITS:0]         t,
  output logic signed [COORD_BITS-1:0]      q_r
);

  localparam int PW = COORD_BITS + T_FRAC_BITS + 3;

  logic signed [COORD_BITS:0]     diff;
  logic signed [T_FRAC_BITS+1:0]  t_s;
  logic signed [PW-1:0]           prod_nxt;
  logic signed [COORD_BITS-1:0]   sh_r;
  logic signed [COORD_BITS-1:0]   a_r;
  logic signed [COORD_BITS-1:0]   q_nxt;

  assign diff     = (COORD_BITS+1)'(b) - (COORD_BITS+1)'(a);
  assign t_s      = $signed({1'b0, t});
  assign prod_nxt = PW'(diff) * PW'(t_s);

  // Only the bits that survive the wrap to coordinate width are kept after the shift.
  assign q_nxt = a_r + sh_r;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      sh_r <= $signed(prod_nxt[T_FRAC_BITS+COORD_BITS-1:T_FRAC_BITS]);
      a_r  <= a;
    end
    if (en.add) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/cubic_bezier_subdivide.sv */
`default_nettype none
// Cubic Bezier split at parameter t by de Casteljau's construction.
// The four control points are written through cfg_chan (index 0..7 selects
// start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y); other
// indexes are ignored. Write them only while no transaction is in flight.
// Each in_chan transaction carries t (unsigned, 1.0 at 2^T_FRAC_BITS) and
// produces one out_chan transaction with the five inner points of the split.
// There are six register stages, a multiplier stage and an add stage for each
// of the three interpolation levels; the first multiplier works in the
// accepting cycle itself. Throughput is one transaction per cycle while
// the receiver keeps out_chan.ready high.
// When the receiver stalls, results back up stage by stage; in_chan.ready
// drops only once every stage holds a transaction, so nothing is dropped or
// repeated. Empty stages keep filling while the output waits.
// Reset clears all stage valid bits and sets every control point to zero.
// cfg_chan is always ready.
module cubic_bezier_subdivide #(
  parameter int COORD_BITS  = cbs_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  cbs_in_if.sink   in_chan,
  cbs_out_if.source out_chan,
  cbs_cfg_if.sink  cfg_chan
);

  localparam int NS = cbs_pkg::NUM_STAGES;

  logic signed [COORD_BITS-1:0] pt_r [4][2];
  logic [NS-1:0]                v_r;
  logic [NS-1:0]                en;
  logic [T_FRAC_BITS:0]         t_r [1:4];

  logic signed [COORD_BITS-1:0] q01_o  [2];
  logic signed [COORD_BITS-1:0] q012_o [2];
  logic signed [COORD_BITS-1:0] q_o    [2];
  logic signed [COORD_BITS-1:0] q123_o [2];
  logic signed [COORD_BITS-1:0] q23_o  [2];

  // Configuration registers.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < 4; p++) begin
        pt_r[p][0] <= '0;
        pt_r[p][1] <= '0;
      end
    end else if (cfg_chan.valid) begin
      case (cbs_pkg::cfg_reg_t'(cfg_chan.index))
        cbs_pkg::CFG_START_X: pt_r[0][0] <= cfg_chan.data;
        cbs_pkg::CFG_START_Y: pt_r[0][1] <= cfg_chan.data;
        cbs_pkg::CFG_CTRL1_X: pt_r[1][0] <= cfg_chan.data;
        cbs_pkg::CFG_CTRL1_Y: pt_r[1][1] <= cfg_chan.data;
        cbs_pkg::CFG_CTRL2_X: pt_r[2][0] <= cfg_chan.data;
        cbs_pkg::CFG_CTRL2_Y: pt_r[2][1] <= cfg_chan.data;
        cbs_pkg::CFG_END_X:   pt_r[3][0] <= cfg_chan.data;
        cbs_pkg::CFG_END_Y:   pt_r[3][1] <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_chan.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_r[1] <= in_chan.param_t;
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k-1]) begin
        t_r[k] <= t_r[k-1];
      end
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    cbs_pkg::lerp_en_t            en_l1, en_l2, en_l3;
    logic signed [COORD_BITS-1:0] q01, q12, q23, q012, q123, q;
    logic signed [COORD_BITS-1:0] q01_d  [3:6];
    logic signed [COORD_BITS-1:0] q23_d  [3:6];
    logic signed [COORD_BITS-1:0] q012_d [5:6];
    logic signed [COORD_BITS-1:0] q123_d [5:6];

    assign en_l1 = '{mul: en[0], add: en[1]};
    assign en_l2 = '{mul: en[2], add: en[3]};
    assign en_l3 = '{mul: en[4], add: en[5]};

    cbs_lerp #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_l01 (
      .clk(clk), .en(en_l1), .a(pt_r[0][ax]), .b(pt_r[1][ax]),
      .t(in_chan.param_t), .q_r(q01));
    cbs_lerp #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_l12 (
      .clk(clk), .en(en_l1), .a(pt_r[1][ax]), .b(pt_r[2][ax]),
      .t(in_chan.param_t), .q_r(q12));
    cbs_lerp #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_l23 (
      .clk(clk), .en(en_l1), .a(pt_r[2][ax]), .b(pt_r[3][ax]),
      .t(in_chan.param_t), .q_r(q23));

    cbs_lerp #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_l012 (
      .clk(clk), .en(en_l2), .a(q01), .b(q12), .t(t_r[2]), .q_r(q012));
    cbs_lerp #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_l123 (
      .clk(clk), .en(en_l2), .a(q12), .b(q23), .t(t_r[2]), .q_r(q123));

    cbs_lerp #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_lq (
      .clk(clk), .en(en_l3), .a(q012), .b(q123), .t(t_r[4]), .q_r(q));

    // Earlier-level points ride along until the curve point is ready.
    always_ff @(posedge clk) begin
      if (en[2]) begin
        q01_d[3] <= q01;
        q23_d[3] <= q23;
      end
      for (int k = 4; k <= 6; k++) begin
        if (en[k-1]) begin
          q01_d[k] <= q01_d[k-1];
          q23_d[k] <= q23_d[k-1];
        end
      end
      if (en[4]) begin
        q012_d[5] <= q012;
        q123_d[5] <= q123;
      end
      if (en[5]) begin
        q012_d[6] <= q012_d[5];
        q123_d[6] <= q123_d[5];
      end
    end

    assign q01_o[ax]  = q01_d[6];
    assign q012_o[ax] = q012_d[6];
    assign q_o[ax]    = q;
    assign q123_o[ax] = q123_d[6];
    assign q23_o[ax]  = q23_d[6];
  end

  assign out_chan.valid          = v_r[NS-1];
  assign out_chan.first_mid_x    = q01_o[0];
  assign out_chan.first_mid_y    = q01_o[1];
  assign out_chan.first_inner_x  = q012_o[0];
  assign out_chan.first_inner_y  = q012_o[1];
  assign out_chan.point_x        = q_o[0];
  assign out_chan.point_y        = q_o[1];
  assign out_chan.second_inner_x = q123_o[0];
  assign out_chan.second_inner_y = q123_o[1];
  assign out_chan.second_mid_x   = q23_o[0];
  assign out_chan.second_mid_y   = q23_o[1];

  // Input back-pressure only appears when the whole pipeline is occupied.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (&v_r))
    else $error("input blocked while a pipeline stage is empty");

  // Occupancy grows by one when a transaction enters and none leaves.
  a_occupancy_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && !(out_chan.valid && out_chan.ready))
    |=> ($countones(v_r) == $past($countones(v_r)) + 1))
    else $error("accepted transaction lost in pipeline");

  // Occupancy shrinks by one when a result leaves and nothing enters.
  a_occupancy_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_chan.valid && in_chan.ready) && out_chan.valid && out_chan.ready)
    |=> ($countones(v_r) == $past($countones(v_r)) - 1))
    else $error("delivered result repeated in pipeline");

endmodule
`default_nettype wire

/* dv/bezier_split_sb_pkg.sv */
package bezier_split_sb_pkg;
  import cbs_pkg::*;

  localparam int COORD_BITS    = COORD_BITS_DEF;
  localparam int T_FRAC_BITS   = T_FRAC_BITS_DEF;
  localparam int NUM_CTRL_REGS = int'(CFG_END_Y) + 1;
  localparam int SPLIT_FIELDS  = 10;
  localparam int MAX_PRINTED   = 40;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [T_FRAC_BITS:0] param_t;
  typedef logic [SPLIT_FIELDS-1:0][COORD_BITS-1:0] split_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Position of the x field of each point in a split; y follows directly.
  typedef enum int {
    F_FIRST_MID    = 0,
    F_FIRST_INNER  = 2,
    F_POINT        = 4,
    F_SECOND_INNER = 6,
    F_SECOND_MID   = 8
  } split_field_e;

  class split_scoreboard;
    coord_t      ctrl_pts [NUM_CTRL_REGS];
    split_t      expected_splits [$];
    param_t      expected_params [$];
    int unsigned mismatch_count;

    function new();
      foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, coord_t value);
      if (idx < NUM_CTRL_REGS) ctrl_pts[idx] = value;
    endfunction

    // One interpolation step with flooring shift, wrapped to the coordinate width.
    static function coord_t lerp_coord(coord_t from_pt, coord_t to_pt, param_t t);
      longint span_prod;
      longint sum;
      span_prod = (longint'(to_pt) - longint'(from_pt)) * longint'(t);
      sum = longint'(from_pt) + (span_prod >>> T_FRAC_BITS);
      return coord_t'(sum[COORD_BITS-1:0]);
    endfunction

    static function string field_name(int idx);
      string base;
      case (split_field_e'(idx - idx % 2))
        F_FIRST_MID:    base = "first_mid";
        F_FIRST_INNER:  base = "first_inner";
        F_POINT:        base = "point";
        F_SECOND_INNER: base = "second_inner";
        default:        base = "second_mid";
      endcase
      return {base, (idx % 2) ? "_y" : "_x"};
    endfunction

    function void note_param(param_t t);
      split_t split;
      coord_t q01, q12, q23, q012, q123;
      for (int axis = 0; axis < 2; axis++) begin
        q01  = lerp_coord(ctrl_pts[int'(CFG_START_X) + axis],
                          ctrl_pts[int'(CFG_CTRL1_X) + axis], t);
        q12  = lerp_coord(ctrl_pts[int'(CFG_CTRL1_X) + axis],
                          ctrl_pts[int'(CFG_CTRL2_X) + axis], t);
        q23  = lerp_coord(ctrl_pts[int'(CFG_CTRL2_X) + axis],
                          ctrl_pts[int'(CFG_END_X) + axis], t);
        q012 = lerp_coord(q01, q12, t);
        q123 = lerp_coord(q12, q23, t);
        split[F_FIRST_MID + axis]    = q01;
        split[F_FIRST_INNER + axis]  = q012;
        split[F_POINT + axis]        = lerp_coord(q012, q123, t);
        split[F_SECOND_INNER + axis] = q123;
        split[F_SECOND_MID + axis]   = q23;
      end
      expected_splits.push_back(split);
      expected_params.push_back(t);
    endfunction

    function int unsigned pending_count();
      return expected_splits.size();
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_split(split_t got);
      split_t want;
      param_t t;
      if (expected_splits.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, point (%0d, %0d)",
                                  $signed(got[F_POINT]), $signed(got[F_POINT + 1])));
        return;
      end
      want = expected_splits.pop_front();
      t    = expected_params.pop_front();
      for (int i = 0; i < SPLIT_FIELDS; i++) begin
        if (got[i] !== want[i])
          report_mismatch($sformatf("t=%0d %s: got %0d, expected %0d", t, field_name(i),
                                    $signed(got[i]), $signed(want[i])));
      end
    endtask
  endclass

endpackage

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbs_pkg::*;
  import bezier_split_sb_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 7;
  localparam int SETTLE_CYCLES    = NUM_STAGES + 6;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int RANDOM_PHASES    = 20;
  localparam int PHASE_ITEMS      = 56;
  localparam int HOLD_PHASE       = 3;
  localparam int TIMEOUT_CYCLES   = 500_000;

  logic clk;
  logic rst_n;
  bit   long_hold_req = 1'b0;
  bit   out_steady = 1'b0;

  split_scoreboard split_sb = new();

  cbs_in_if  #(.T_FRAC_BITS(T_FRAC_BITS)) in_chan ();
  cbs_out_if #(.COORD_BITS(COORD_BITS))   out_chan ();
  cbs_cfg_if #(.COORD_BITS(COORD_BITS))   cfg_chan ();

  cubic_bezier_subdivide #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

  // All three channels are sampled here, on the same edge values the block sees.
  always @(posedge clk) begin : monitor
    split_t got;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) split_sb.write_reg(cfg_chan.index, cfg_chan.data);
      if (in_chan.valid && in_chan.ready) split_sb.note_param(in_chan.param_t);
      if (out_chan.valid && out_chan.ready) begin
        got[F_FIRST_MID]        = out_chan.first_mid_x;
        got[F_FIRST_MID + 1]    = out_chan.first_mid_y;
        got[F_FIRST_INNER]      = out_chan.first_inner_x;
        got[F_FIRST_INNER + 1]  = out_chan.first_inner_y;
        got[F_POINT]            = out_chan.point_x;
        got[F_POINT + 1]        = out_chan.point_y;
        got[F_SECOND_INNER]     = out_chan.second_inner_x;
        got[F_SECOND_INNER + 1] = out_chan.second_inner_y;
        got[F_SECOND_MID]       = out_chan.second_mid_x;
        got[F_SECOND_MID + 1]   = out_chan.second_mid_y;
        split_sb.check_split(got);
      end
    end
  end

  // Receiver side. A long hold, when requested, is counted here so that the
  // sender can keep offering transactions meanwhile.
  initial begin : result_sink
    int stretch;
    int held;
    int roll;
    logic level;
    out_chan.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_chan.ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        long_hold_req = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (out_steady || roll < 50) begin
          level   = 1'b1;
          stretch = $urandom_range(1, 12);
        end else if (roll < 85) begin
          level   = 1'b0;
          stretch = $urandom_range(1, 3);
        end else begin
          level   = 1'b0;
          stretch = $urandom_range(4, 30);
        end
        out_chan.ready <= level;
        repeat (stretch) @(posedge clk);
      end
    end
  end

  function automatic int input_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic param_t pick_param();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return ($urandom_range(0, 1) != 0) ? param_t'(1 << T_FRAC_BITS) : '0;
    if (roll < 75) return param_t'($urandom_range(0, 1 << T_FRAC_BITS));
    return param_t'($urandom_range(0, (1 << (T_FRAC_BITS + 1)) - 1));
  endfunction

  function automatic coord_t pick_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
      default: begin
        case ($urandom_range(0, 5))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return '1;
          4: return coord_t'(1);
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Leaves valid high when no gap follows, so back-to-back transactions flow.
  task automatic send_param(param_t t, bit no_gap);
    int gap;
    in_chan.valid   <= 1'b1;
    in_chan.param_t <= t;
    do @(posedge clk); while (!in_chan.ready);
    gap = no_gap ? 0 : input_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, coord_t data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  // Writes all control points; optionally adds a write to an unused index,
  // which the block must ignore.
  task automatic load_points(input coord_t pts [NUM_CTRL_REGS], bit with_stray);
    cfg_reg_t sel;
    logic [CFG_IDX_BITS-1:0] stray_idx;
    sel = sel.first();
    repeat (sel.num()) begin
      write_cfg(sel, pts[sel]);
      sel = sel.next();
    end
    if (with_stray) begin
      stray_idx = CFG_IDX_BITS'($urandom_range(NUM_CTRL_REGS, (1 << CFG_IDX_BITS) - 1));
      write_cfg(stray_idx, coord_t'($urandom));
    end
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One edge first, so that a transaction accepted on the current edge is counted.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (split_sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    coord_t pts [NUM_CTRL_REGS];
    param_t corner_params [$];
    int     pt_mode;
    int     phase_items;
    bit     burst;

    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.param_t = '0;
    cfg_chan.valid  = 1'b0;
    cfg_chan.index  = '0;
    cfg_chan.data   = '0;
    corner_params = '{0, 65536, 131071, 1, 2, 32768, 65535, 65537, 98304, 131070, 16384};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Control points are all zero straight out of reset.
    for (int i = 0; i < 3; i++) send_param(corner_params[i], 1'b0);
    drain_results();

    // Full-scale swings between neighbors, the worst case for the differences.
    pts[CFG_START_X] = COORD_MIN;  pts[CFG_START_Y] = COORD_MAX;
    pts[CFG_CTRL1_X] = COORD_MAX;  pts[CFG_CTRL1_Y] = COORD_MIN;
    pts[CFG_CTRL2_X] = COORD_MIN;  pts[CFG_CTRL2_Y] = COORD_MAX;
    pts[CFG_END_X]   = COORD_MAX;  pts[CFG_END_Y]   = COORD_MIN;
    load_points(pts, 1'b1);
    foreach (corner_params[i]) send_param(corner_params[i], ($urandom_range(0, 1) != 0));
    drain_results();

    pts[CFG_START_X] = COORD_MAX;  pts[CFG_START_Y] = '1;
    pts[CFG_CTRL1_X] = COORD_MIN;  pts[CFG_CTRL1_Y] = coord_t'(1);
    pts[CFG_CTRL2_X] = COORD_MIN;  pts[CFG_CTRL2_Y] = COORD_MIN;
    pts[CFG_END_X]   = COORD_MAX;  pts[CFG_END_Y]   = '0;
    load_points(pts, 1'b1);
    foreach (corner_params[i]) send_param(corner_params[i], ($urandom_range(0, 1) != 0));
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pt_mode = $urandom_range(0, 2);
      foreach (pts[i]) pts[i] = pick_coord(pt_mode);
      load_points(pts, ($urandom_range(0, 1) != 0));
      burst       = ($urandom_range(0, 3) == 0);
      out_steady  = ($urandom_range(0, 4) == 0);
      phase_items = PHASE_ITEMS;
      if (phase == HOLD_PHASE) begin
        // Keep offering while the receiver holds off, so the pipeline backs up.
        out_steady    = 1'b0;
        burst         = 1'b1;
        phase_items   = 90;
        long_hold_req = 1'b1;
      end
      repeat (phase_items) send_param(pick_param(), burst);
      drain_results();
    end

    if (split_sb.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
